// ===== hw/rtl/offset_calibrated_beam_detector_defines.svh =====
// Assertion macros for the beam detector RTL.
`ifndef OFFSET_CALIBRATED_BEAM_DETECTOR_DEFINES_SVH
`define OFFSET_CALIBRATED_BEAM_DETECTOR_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define OCBD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define OCBD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ===== hw/rtl/ocbd_pkg.sv =====
// Package with the constants, codes and types of the beam detector.
`default_nettype none

package ocbd_pkg;

    // Block configuration.
    localparam int CHANNELS    = 16;
    localparam int CAL_FRAMES  = 16;
    localparam int SAMPLE_BITS = 12;

    // Fixed field widths.
    localparam int CH_W   = 4;
    localparam int SMP_W  = 12;
    localparam int SUM_W  = 16;
    localparam int OFS_W  = 12;
    localparam int THR_W  = 13;
    localparam int CNT_W  = 6;
    localparam int DIFF_W = SMP_W + 2;

    // Channel memory address width.
    localparam int CH_AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // Effective sample width and its mask.
    localparam int SMP_EFF = (SAMPLE_BITS < SMP_W) ? SAMPLE_BITS : SMP_W;
    localparam logic [SMP_W-1:0] SMP_MASK = SMP_W'((33'd1 << SMP_EFF) - 33'd1);

    // Saturation limit of a channel sum.
    localparam logic [SUM_W-1:0] SUM_MAX = '1;

    // Calibration counter codes: all ones is the idle value (minus one).
    localparam logic [CNT_W-1:0] CNT_IDLE = '1;
    localparam logic [CNT_W-1:0] CNT_LOAD = CNT_W'(CAL_FRAMES);

    // Division of a sum by CAL_FRAMES as an exact reciprocal multiplication.
    localparam int DIV_SHIFT = SUM_W + $clog2(CAL_FRAMES);
    localparam int DIV_RW    = SUM_W + 1;
    localparam int PROD_W    = SUM_W + DIV_RW;
    localparam logic [DIV_RW-1:0] DIV_RECIP =
        DIV_RW'(((64'd1 << DIV_SHIFT) + 64'(CAL_FRAMES) - 64'd1) / 64'(CAL_FRAMES));

    // Configuration port.
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam int REG_IW = APB_AW - 2;
    localparam logic [REG_IW-1:0] REG_DETECT_THRESHOLD = REG_IW'(0);
    localparam logic [THR_W-1:0]  THR_RESET = THR_W'(256);

    // Stream widths.
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 8;

    // Input operation codes.
    typedef enum logic {
        OP_SAMPLE    = 1'b0,
        OP_CAL_START = 1'b1
    } t_op;

    // One input item as it sits in the update stage.
    typedef struct packed {
        t_op              op;
        logic [CH_W-1:0]  ch;
        logic [SMP_W-1:0] smp;
        logic             fend;
    } t_item;

    // Outcome of the update stage for one item.
    typedef struct packed {
        logic             sum_we;
        logic [SUM_W-1:0] sum_wdata;
        logic             ofs_we;
        logic [OFS_W-1:0] ofs_wdata;
        logic             res_vld;
        logic             beam;
        logic             cal;
        logic [CNT_W-1:0] cnt_next;
    } t_upd;

endpackage

`default_nettype wire

// ===== hw/rtl/ocbd_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module ocbd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, old data on a same-address write.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/ocbd_cfg.sv =====
// APB register file holding the detection threshold.
`default_nettype none

module ocbd_cfg
    import ocbd_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready,
    output logic      [THR_W-1:0]  o_thr
);

    logic [THR_W-1:0]  r_thr;
    logic [REG_IW-1:0] w_idx;
    logic              w_wr;

    assign pready = 1'b1;
    assign w_idx  = paddr[APB_AW-1:2];
    assign w_wr   = psel && penable && pwrite && pready;

    // Register write in the access cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
        end else if (w_wr && (w_idx == REG_DETECT_THRESHOLD)) begin
            r_thr <= pwdata[THR_W-1:0];
        end
    end

    // Read decode; the threshold reads back sign-extended.
    always_comb begin
        unique case (w_idx)
            REG_DETECT_THRESHOLD: prdata = APB_DW'($signed(r_thr));
            default:              prdata = '0;
        endcase
    end

    assign o_thr = r_thr;

endmodule

`default_nettype wire

// ===== hw/rtl/ocbd_calc.sv =====
// Update stage arithmetic: sum accumulation, offset division and threshold compare.
`default_nettype none

module ocbd_calc
    import ocbd_pkg::*;
(
    input  wire t_item              i_item,
    input  wire logic [CNT_W-1:0]   i_cnt,
    input  wire logic [THR_W-1:0]   i_thr,
    input  wire logic [SUM_W-1:0]   i_sum,
    input  wire logic [OFS_W-1:0]   i_ofs,
    output t_upd                    o_upd
);

    logic              w_in_range;
    logic              w_is_smp;
    logic              w_cnt_pos;
    logic              w_cnt_zero;
    logic              w_cnt_idle;
    logic [SUM_W:0]    w_sum_add;
    logic [SUM_W-1:0]  w_sum_sat;
    logic [PROD_W-1:0] w_prod;
    logic [OFS_W-1:0]  w_quot;
    logic [OFS_W-1:0]  w_ofs_use;
    logic signed [DIFF_W-1:0] w_diff;
    logic signed [DIFF_W-1:0] w_thr_ext;

    // Counter decode: all ones means idle; a set top bit never counts as positive.
    assign w_cnt_idle = (i_cnt == CNT_IDLE);
    assign w_cnt_zero = (i_cnt == '0);
    assign w_cnt_pos  = !i_cnt[CNT_W-1] && !w_cnt_zero;

    assign w_in_range = (int'(i_item.ch) < CHANNELS);
    assign w_is_smp   = (i_item.op == OP_SAMPLE) && w_in_range;

    // Saturating accumulation of the sample.
    assign w_sum_add = {1'b0, i_sum} + (SUM_W + 1)'(i_item.smp);
    assign w_sum_sat = w_sum_add[SUM_W] ? SUM_MAX : w_sum_add[SUM_W-1:0];

    // Sum divided by the frame count, low bits of the quotient kept.
    assign w_prod = PROD_W'(i_sum) * PROD_W'(DIV_RECIP);
    assign w_quot = w_prod[DIV_SHIFT +: OFS_W];

    // In the last calibration frame the fresh offset is used at once.
    assign w_ofs_use = w_cnt_zero ? w_quot : i_ofs;
    assign w_diff    = $signed(DIFF_W'(i_item.smp)) - $signed(DIFF_W'(w_ofs_use));
    assign w_thr_ext = DIFF_W'($signed(i_thr));

    always_comb begin
        o_upd           = '0;
        o_upd.sum_wdata = w_sum_sat;
        o_upd.ofs_wdata = w_quot;
        o_upd.sum_we    = w_is_smp && w_cnt_pos;
        o_upd.ofs_we    = w_is_smp && w_cnt_zero;
        o_upd.res_vld   = w_is_smp;
        o_upd.beam      = (w_diff >= w_thr_ext);
        o_upd.cal       = !w_cnt_idle;
        // Start loads the counter; a frame end steps it down towards idle.
        if (i_item.op == OP_CAL_START) begin
            o_upd.cnt_next = CNT_LOAD;
        end else if (i_item.fend && !w_cnt_idle) begin
            o_upd.cnt_next = CNT_W'(i_cnt - 1'b1);
        end else begin
            o_upd.cnt_next = i_cnt;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/offset_calibrated_beam_detector.sv =====
// Top level of the offset-calibrated beam detector.
//
// The detector takes one input beat per clock cycle unless a full, unready output holds
// it. The accepting edge registers the beat and reads the channel's sum and offset
// from two RAMs; the update stage then works out the update, and the edge on which it
// advances writes it back and loads the output register. That read-modify-write of the
// per-channel RAMs sets the rate: a result forwarded from the write of the previous
// beat lets the same channel follow in the very next cycle, so the block sustains one
// beat per cycle while the output is not stalled.
// Valid bits per channel stand for the zeroed sums after a start-calibration beat
// and for the zeroed state after reset, so there is no clearing pass.
// The threshold register at byte address 0 may be written only while the block is idle.
`default_nettype none

`include "offset_calibrated_beam_detector_defines.svh"

module offset_calibrated_beam_detector
    import ocbd_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // APB configuration port
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [APB_AW-1:0]      paddr,
    input  wire logic [APB_DW-1:0]      pwdata,
    output logic      [APB_DW-1:0]      prdata,
    output logic                        pready,
    // Input stream
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,  // [3:0] channel, [15:4] sample
    input  wire logic                   s_axis_tuser,  // [0] op
    input  wire logic                   s_axis_tlast,  // frame_end
    // Result stream
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic      [OUT_TDATA_W-1:0] m_axis_tdata,  // [3:0] out_channel, [4] beam_state
    output logic                        m_axis_tuser   // [0] calibrating
);

    logic [THR_W-1:0]    w_thr;
    logic                w_acc;
    logic                w_adv;
    t_item               w_in_item;
    t_upd                w_upd;

    logic                r_s1_vld;
    t_item               r_s1;
    logic [CNT_W-1:0]    r_cnt;
    logic [CHANNELS-1:0] r_sum_vld;
    logic [CHANNELS-1:0] r_ofs_vld;

    logic                r_fsum_vld;
    logic [CH_AW-1:0]    r_fsum_addr;
    logic [SUM_W-1:0]    r_fsum_data;
    logic                r_fofs_vld;
    logic [CH_AW-1:0]    r_fofs_addr;
    logic [OFS_W-1:0]    r_fofs_data;

    logic                r_out_vld;
    logic [CH_W-1:0]     r_out_ch;
    logic                r_out_beam;
    logic                r_out_cal;

    logic [CH_AW-1:0]    w_raddr;
    logic [CH_AW-1:0]    w_s1_addr;
    logic [SUM_W-1:0]    w_sum_rd;
    logic [OFS_W-1:0]    w_ofs_rd;
    logic [SUM_W-1:0]    w_sum_cur;
    logic [OFS_W-1:0]    w_ofs_cur;

    // Configuration registers.
    ocbd_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_thr   (w_thr)
    );

    // Handshake: the update stage advances unless its result finds the output full.
    assign w_adv = r_s1_vld && (!w_upd.res_vld || !r_out_vld || m_axis_tready);
    assign s_axis_tready = !r_s1_vld || w_adv;
    assign w_acc = s_axis_tvalid && s_axis_tready;

    // Input beat unpacked, sample masked to its used width.
    always_comb begin
        w_in_item.op   = t_op'(s_axis_tuser);
        w_in_item.ch   = s_axis_tdata[CH_W-1:0];
        w_in_item.smp  = s_axis_tdata[CH_W +: SMP_W] & SMP_MASK;
        w_in_item.fend = s_axis_tlast;
    end

    assign w_raddr   = CH_AW'(w_in_item.ch);
    assign w_s1_addr = CH_AW'(r_s1.ch);

    // Per-channel state memories, read as a beat is accepted.
    ocbd_ram #(.WIDTH(SUM_W), .DEPTH(CHANNELS)) u_sum_ram (
        .i_clk   (i_clk),
        .i_we    (w_adv && w_upd.sum_we),
        .i_waddr (w_s1_addr),
        .i_wdata (w_upd.sum_wdata),
        .i_re    (w_acc),
        .i_raddr (w_raddr),
        .o_rdata (w_sum_rd)
    );

    ocbd_ram #(.WIDTH(OFS_W), .DEPTH(CHANNELS)) u_ofs_ram (
        .i_clk   (i_clk),
        .i_we    (w_adv && w_upd.ofs_we),
        .i_waddr (w_s1_addr),
        .i_wdata (w_upd.ofs_wdata),
        .i_re    (w_acc),
        .i_raddr (w_raddr),
        .o_rdata (w_ofs_rd)
    );

    // Current entry: forwarded write first, then valid memory data, else zero.
    always_comb begin
        if (r_fsum_vld && (r_fsum_addr == w_s1_addr)) begin
            w_sum_cur = r_fsum_data;
        end else if (r_sum_vld[w_s1_addr]) begin
            w_sum_cur = w_sum_rd;
        end else begin
            w_sum_cur = '0;
        end
        if (r_fofs_vld && (r_fofs_addr == w_s1_addr)) begin
            w_ofs_cur = r_fofs_data;
        end else if (r_ofs_vld[w_s1_addr]) begin
            w_ofs_cur = w_ofs_rd;
        end else begin
            w_ofs_cur = '0;
        end
    end

    // Update arithmetic.
    ocbd_calc u_calc (
        .i_item (r_s1),
        .i_cnt  (r_cnt),
        .i_thr  (w_thr),
        .i_sum  (w_sum_cur),
        .i_ofs  (w_ofs_cur),
        .o_upd  (w_upd)
    );

    // Update stage holding register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (w_acc) begin
            r_s1_vld <= 1'b1;
        end else if (w_adv) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_s1 <= w_in_item;
        end
    end

    // Counter, valid bits and forwarding registers change as a beat completes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt      <= CNT_IDLE;
            r_sum_vld  <= '0;
            r_ofs_vld  <= '0;
            r_fsum_vld <= 1'b0;
            r_fofs_vld <= 1'b0;
        end else if (w_adv) begin
            r_cnt      <= w_upd.cnt_next;
            r_fsum_vld <= w_upd.sum_we;
            r_fofs_vld <= w_upd.ofs_we;
            if (r_s1.op == OP_CAL_START) begin
                r_sum_vld <= '0;
            end else if (w_upd.sum_we) begin
                r_sum_vld[w_s1_addr] <= 1'b1;
            end
            if (w_upd.ofs_we) begin
                r_ofs_vld[w_s1_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_fsum_addr <= w_s1_addr;
            r_fsum_data <= w_upd.sum_wdata;
            r_fofs_addr <= w_s1_addr;
            r_fofs_data <= w_upd.ofs_wdata;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv && w_upd.res_vld) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_upd.res_vld) begin
            r_out_ch   <= r_s1.ch;
            r_out_beam <= w_upd.beam;
            r_out_cal  <= w_upd.cal;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = OUT_TDATA_W'({r_out_beam, r_out_ch});
    assign m_axis_tuser  = r_out_cal;

    // Sums change only while the counter counts calibration frames.
    `OCBD_ASSERT_IMP(a_sum_wr_cal, i_clk, i_rst_n, w_adv && w_upd.sum_we,
        !r_cnt[CNT_W-1] && (r_cnt != '0))
    // Offsets change only in the last calibration frame.
    `OCBD_ASSERT_IMP(a_ofs_wr_last, i_clk, i_rst_n, w_adv && w_upd.ofs_we, r_cnt == '0)
    // A completed start beat loads the counter.
    `OCBD_ASSERT_NXT(a_start_load, i_clk, i_rst_n, w_adv && (r_s1.op == OP_CAL_START),
        r_cnt == CNT_LOAD)
    // A completed start beat leaves every sum cleared.
    `OCBD_ASSERT_NXT(a_start_clear, i_clk, i_rst_n, w_adv && (r_s1.op == OP_CAL_START),
        (r_sum_vld == '0) && !r_fsum_vld)

endmodule

`default_nettype wire
